// File: design/btpc_pkg.sv
package btpc_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 48;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_CALIB    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_CALIB_A = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_CALIB_B = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_CALIB_C = 2'd3;

   // One quotient bit is resolved per divider stage.
   localparam int DIV_STAGES = 64;

   // The fine temperature is the sum of two 23-bit signed terms, so it fits 24 bits signed.
   localparam int FINE_W = 24;

   localparam logic signed [FINE_W:0] FINE_OFFSET  = 25'sd128000;
   localparam logic [20:0]            PRESS_BASE   = 21'd1048576;
   localparam logic [11:0]            PRESS_SCALE  = 12'd3125;
   localparam logic [35:0]            TEMP_ROUND   = 36'd128;
   localparam logic [63:0]            DIVISOR_BIAS = 64'h0000_8000_0000_0000;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } btpc_req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_q24_8;
      logic               divisor_zero;
   } btpc_rsp_type;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } btpc_calib_type;

   typedef struct packed {
      logic signed [FINE_W-1:0] fine;
      logic [19:0]              adc_p;
   } btpc_fine_type;

   typedef struct packed {
      logic [63:0]        dividend;
      logic [30:0]        divisor;
      logic               neg;
      logic               dz;
      logic signed [31:0] temp;
   } btpc_divin_type;

   typedef struct packed {
      logic [63:0]        quot;
      logic               neg;
      logic               dz;
      logic signed [31:0] temp;
   } btpc_divout_type;

   typedef struct packed {
      logic [30:0]        rem;
      logic [63:0]        dq;
      logic [30:0]        divisor;
      logic               neg;
      logic               dz;
      logic signed [31:0] temp;
   } btpc_divstage_type;

endpackage

// File: design/baro_temp_press_compensate.sv
// Channel   Direction  Handshake                Payload
// req_      in         req_valid / req_stall    btpc_req_type (raw temperature, raw pressure)
// rsp_      out        rsp_valid / rsp_stall    btpc_rsp_type (temperature, pressure, flag)
// csr_      in         csr_we                   csr_index selects, csr_wdata (48 bits)
//
// One beat is accepted every cycle while req_stall is low; most of the pipeline is the
// 64-stage restoring divider that resolves one quotient bit per stage.
// Reset is synchronous and clears all valid bits and the calibration registers.
// The whole pipeline advances unless a result is held by rsp_stall; the output
// register then holds its beat and req_stall rises in the same cycle.
module baro_temp_press_compensate (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  btpc_pkg::btpc_req_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output btpc_pkg::btpc_rsp_type                 rsp_data,
   input  logic                                   csr_we,
   input  logic [btpc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [btpc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // Calibration words, packed three to a register.
   logic [btpc_pkg::CSR_DATA_W-1:0] temp_calib_ff;
   logic [btpc_pkg::CSR_DATA_W-1:0] press_calib_a_ff;
   logic [btpc_pkg::CSR_DATA_W-1:0] press_calib_b_ff;
   logic [btpc_pkg::CSR_DATA_W-1:0] press_calib_c_ff;
   btpc_pkg::btpc_calib_type        calib;

   // Global advance: every stage moves unless the output beat is held.
   logic adv;

   logic                      temp_valid;
   btpc_pkg::btpc_fine_type   temp_data;
   logic                      press_valid;
   btpc_pkg::btpc_divin_type  press_data;
   logic                      div_valid;
   btpc_pkg::btpc_divout_type div_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff    <= '0;
         press_calib_a_ff <= '0;
         press_calib_b_ff <= '0;
         press_calib_c_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            btpc_pkg::CSR_TEMP_CALIB:    temp_calib_ff    <= csr_wdata;
            btpc_pkg::CSR_PRESS_CALIB_A: press_calib_a_ff <= csr_wdata;
            btpc_pkg::CSR_PRESS_CALIB_B: press_calib_b_ff <= csr_wdata;
            btpc_pkg::CSR_PRESS_CALIB_C: press_calib_c_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The calibration must only be rewritten by the user while the pipeline is empty (the block
   // does not enforce this), so every stage reads it directly instead of carrying a copy.
   always_comb begin
      calib.t1 = temp_calib_ff[15:0];
      calib.t2 = temp_calib_ff[31:16];
      calib.t3 = temp_calib_ff[47:32];
      calib.p1 = press_calib_a_ff[15:0];
      calib.p2 = press_calib_a_ff[31:16];
      calib.p3 = press_calib_a_ff[47:32];
      calib.p4 = press_calib_b_ff[15:0];
      calib.p5 = press_calib_b_ff[31:16];
      calib.p6 = press_calib_b_ff[47:32];
      calib.p7 = press_calib_c_ff[15:0];
      calib.p8 = press_calib_c_ff[31:16];
      calib.p9 = press_calib_c_ff[47:32];
   end

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // Temperature: four stages produce the fine temperature.
   btpc_temp u_temp (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .calib     (calib),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (temp_valid),
      .out_data  (temp_data)
   );

   // Pressure polynomial: seven stages build dividend and divisor magnitudes.
   btpc_press u_press (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .calib     (calib),
      .in_valid  (temp_valid),
      .in_data   (temp_data),
      .out_valid (press_valid),
      .out_data  (press_data)
   );

   btpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (press_valid),
      .in_data   (press_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   // Correction terms, saturation and the output register.
   btpc_post u_post (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .calib     (calib),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

// File: design/btpc_temp.sv
module btpc_temp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  btpc_pkg::btpc_calib_type calib,
   input  logic                     in_valid,
   input  btpc_pkg::btpc_req_type   in_data,
   output logic                     out_valid,
   output btpc_pkg::btpc_fine_type  out_data
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;

   logic signed [17:0] s1_a_ff, s1_a_in;
   logic signed [16:0] s1_d_ff, s1_d_in;
   logic [19:0]        s1_adcp_ff, s2_adcp_ff, s3_adcp_ff;
   logic signed [33:0] s2_m1_ff, s2_m1_in;
   logic signed [33:0] dd_full;
   logic [31:0]        s2_dd_ff, s2_dd_in;
   logic signed [22:0] s3_v1_ff, s3_v1_in;
   logic signed [36:0] s3_m2_ff, s3_m2_in;
   logic signed [22:0] v2;
   btpc_pkg::btpc_fine_type s4_ff, s4_in;

   always_comb begin
      s1_a_in  = $signed({1'b0, in_data.raw_temperature[19:3]})
               - $signed({1'b0, calib.t1, 1'b0});
      s1_d_in  = $signed({1'b0, in_data.raw_temperature[19:4]})
               - $signed({1'b0, calib.t1});
      s2_m1_in = s1_a_ff * calib.t2;
      dd_full  = s1_d_ff * s1_d_ff;
      s2_dd_in = dd_full[31:0];
      s3_v1_in = s2_m1_ff[33:11];
      s3_m2_in = $signed({1'b0, s2_dd_ff[31:12]}) * calib.t3;
      v2       = s3_m2_ff[36:14];
      s4_in.fine  = $signed({s3_v1_ff[22], s3_v1_ff}) + $signed({v2[22], v2});
      s4_in.adc_p = s3_adcp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_a_ff    <= s1_a_in;
         s1_d_ff    <= s1_d_in;
         s1_adcp_ff <= in_data.raw_pressure;
         s2_m1_ff   <= s2_m1_in;
         s2_dd_ff   <= s2_dd_in;
         s2_adcp_ff <= s1_adcp_ff;
         s3_v1_ff   <= s3_v1_in;
         s3_m2_ff   <= s3_m2_in;
         s3_adcp_ff <= s2_adcp_ff;
         s4_ff      <= s4_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_ff;

endmodule

// File: design/btpc_press.sv
module btpc_press (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  btpc_pkg::btpc_calib_type calib,
   input  logic                     in_valid,
   input  btpc_pkg::btpc_fine_type  in_data,
   output logic                     out_valid,
   output btpc_pkg::btpc_divin_type out_data
);

   logic [6:0] valid_ff;

   // Temperature result and fine offset.
   logic signed [35:0] f36, t36;
   logic signed [31:0] p1_temp_ff, p1_temp_in;
   logic signed [24:0] p1_v1_ff, p1_v1_in;
   logic [19:0]        p1_adcp_ff, p2_adcp_ff, p3_adcp_ff, p4_adcp_ff;

   // Square and linear terms.
   logic signed [49:0] sq_full;
   logic [45:0]        p2_sq_ff, p2_sq_in;
   logic signed [40:0] p2_m5_ff, p2_m5_in, p2_m2_ff, p2_m2_in;
   logic signed [31:0] p2_temp_ff;

   // Quadratic terms.
   logic signed [62:0] p3_s6_ff, p3_s6_in, p3_s3_ff, p3_s3_in;
   logic signed [40:0] p3_m5_ff, p3_m2_ff;
   logic signed [31:0] p3_temp_ff;

   // Sums.
   logic [63:0]        p4_v2_ff, p4_v2_in, p4_v1b_ff, p4_v1b_in;
   logic signed [31:0] p4_temp_ff;

   logic [20:0]        pp;
   logic [63:0]        p5_num_ff, p5_num_in, p5_x_ff, p5_x_in;
   logic signed [31:0] p5_temp_ff;

   logic [75:0]        numw;
   logic [79:0]        dvw;
   logic [63:0]        p6_num_ff;
   logic [30:0]        p6_div_ff;
   logic signed [31:0] p6_temp_ff;

   btpc_pkg::btpc_divin_type p7_ff, p7_in;

   always_comb begin
      f36        = $signed({{(36 - btpc_pkg::FINE_W){in_data.fine[btpc_pkg::FINE_W-1]}},
                            in_data.fine});
      t36        = (f36 <<< 2) + f36 + $signed(btpc_pkg::TEMP_ROUND);
      p1_temp_in = $signed({{4{t36[35]}}, t36[35:8]});
      p1_v1_in   = $signed({in_data.fine[btpc_pkg::FINE_W-1], in_data.fine})
                 - btpc_pkg::FINE_OFFSET;

      sq_full  = p1_v1_ff * p1_v1_ff;
      p2_sq_in = sq_full[45:0];
      p2_m5_in = p1_v1_ff * calib.p5;
      p2_m2_in = p1_v1_ff * calib.p2;

      p3_s6_in = $signed({1'b0, p2_sq_ff}) * calib.p6;
      p3_s3_in = $signed({1'b0, p2_sq_ff}) * calib.p3;

      p4_v2_in  = 64'(p3_s6_ff) + (64'(p3_m5_ff) << 17) + (64'(calib.p4) << 35);
      p4_v1b_in = 64'($signed(p3_s3_ff[62:8])) + (64'(p3_m2_ff) << 12);

      pp        = btpc_pkg::PRESS_BASE - {1'b0, p4_adcp_ff};
      p5_num_in = {12'b0, pp, 31'b0} - p4_v2_ff;
      p5_x_in   = p4_v1b_ff + btpc_pkg::DIVISOR_BIAS;

      numw = p5_num_ff * btpc_pkg::PRESS_SCALE;
      dvw  = p5_x_ff * calib.p1;

      p7_in.neg      = p6_num_ff[63] ^ p6_div_ff[30];
      p7_in.dz       = (p6_div_ff == 31'd0);
      p7_in.dividend = p6_num_ff[63] ? (64'd0 - p6_num_ff) : p6_num_ff;
      p7_in.divisor  = p6_div_ff[30] ? (31'd0 - p6_div_ff) : p6_div_ff;
      p7_in.temp     = p6_temp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_temp_ff <= p1_temp_in;
         p1_v1_ff   <= p1_v1_in;
         p1_adcp_ff <= in_data.adc_p;

         p2_sq_ff   <= p2_sq_in;
         p2_m5_ff   <= p2_m5_in;
         p2_m2_ff   <= p2_m2_in;
         p2_temp_ff <= p1_temp_ff;
         p2_adcp_ff <= p1_adcp_ff;

         p3_s6_ff   <= p3_s6_in;
         p3_s3_ff   <= p3_s3_in;
         p3_m5_ff   <= p2_m5_ff;
         p3_m2_ff   <= p2_m2_ff;
         p3_temp_ff <= p2_temp_ff;
         p3_adcp_ff <= p2_adcp_ff;

         p4_v2_ff   <= p4_v2_in;
         p4_v1b_ff  <= p4_v1b_in;
         p4_temp_ff <= p3_temp_ff;
         p4_adcp_ff <= p3_adcp_ff;

         p5_num_ff  <= p5_num_in;
         p5_x_ff    <= p5_x_in;
         p5_temp_ff <= p4_temp_ff;

         p6_num_ff  <= numw[63:0];
         p6_div_ff  <= dvw[63:33];
         p6_temp_ff <= p5_temp_ff;

         p7_ff      <= p7_in;
      end
   end

   assign out_valid = valid_ff[6];
   assign out_data  = p7_ff;

endmodule

// File: design/btpc_div.sv
module btpc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  btpc_pkg::btpc_divin_type  in_data,
   output logic                      out_valid,
   output btpc_pkg::btpc_divout_type out_data
);

   localparam int N = btpc_pkg::DIV_STAGES;

   logic [N-1:0]                valid_ff;
   btpc_pkg::btpc_divstage_type head;
   btpc_pkg::btpc_divstage_type src      [N];
   btpc_pkg::btpc_divstage_type stage_in [N];
   btpc_pkg::btpc_divstage_type stage_ff [N];

   always_comb begin
      head.rem     = '0;
      head.dq      = in_data.dividend;
      head.divisor = in_data.divisor;
      head.neg     = in_data.neg;
      head.dz      = in_data.dz;
      head.temp    = in_data.temp;
   end

   for (genvar k = 0; k < N; k++) begin : g_src
      if (k == 0) begin : g_head
         assign src[k] = head;
      end else begin : g_link
         assign src[k] = stage_ff[k-1];
      end
   end

   // Restoring division: each stage shifts in one dividend bit and
   // shifts one quotient bit into the freed low end of dq.
   always_comb begin
      logic [31:0] trial;
      logic [31:0] diff;
      logic        ge;
      for (int k = 0; k < N; k++) begin
         trial = {src[k].rem, src[k].dq[63]};
         diff  = trial - {1'b0, src[k].divisor};
         ge    = (trial >= {1'b0, src[k].divisor});
         stage_in[k]     = src[k];
         stage_in[k].rem = ge ? diff[30:0] : trial[30:0];
         stage_in[k].dq  = {src[k].dq[62:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < N; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_valid     = valid_ff[N-1];
   assign out_data.quot = stage_ff[N-1].dq;
   assign out_data.neg  = stage_ff[N-1].neg;
   assign out_data.dz   = stage_ff[N-1].dz;
   assign out_data.temp = stage_ff[N-1].temp;

endmodule

// File: design/btpc_post.sv
module btpc_post (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  btpc_pkg::btpc_calib_type  calib,
   input  logic                      in_valid,
   input  btpc_pkg::btpc_divout_type in_data,
   output logic                      out_valid,
   output btpc_pkg::btpc_rsp_type    out_data
);

   logic [6:0] valid_ff;
   logic       rsp_valid_ff;

   logic [63:0] q1_qs_ff, q2_qs_ff, q3_qs_ff, q4_qs_ff, q5_qs_ff;
   logic [6:0]  dz_ff;
   logic signed [31:0] q1_temp_ff, q2_temp_ff, q3_temp_ff, q4_temp_ff;
   logic signed [31:0] q5_temp_ff, q6_temp_ff, q7_temp_ff;

   logic signed [50:0] q2_s13_ff;
   logic signed [79:0] bw;
   logic [63:0]        q2_b_ff;

   logic [63:0]        e;
   logic [63:0]        q3_pp0_ff, q3_pp0_in;
   logic [31:0]        q3_pp1_ff, q3_pp1_in;
   logic signed [44:0] q3_b_ff, q4_b_ff, q5_b_ff;

   logic [63:0]        q4_sq_ff, q4_sq_in;
   logic signed [79:0] aw;
   logic [63:0]        q5_ap_ff;
   logic [63:0]        q6_sum_ff, q6_sum_in;
   logic [63:0]        q7_pf_ff, q7_pf_in;

   btpc_pkg::btpc_rsp_type rsp_ff, rsp_in;

   always_comb begin
      bw = $signed(q1_qs_ff) * calib.p8;

      // Low 64 bits of the square from 32-bit halves; cross terms are equal.
      e         = 64'(q2_s13_ff);
      q3_pp0_in = e[31:0] * e[31:0];
      q3_pp1_in = e[63:32] * e[31:0];
      q4_sq_in  = q3_pp0_ff + {q3_pp1_ff[30:0], 33'b0};

      aw = $signed(q4_sq_ff) * calib.p9;

      q6_sum_in = q5_qs_ff + 64'($signed(q5_ap_ff[63:25])) + 64'(q5_b_ff);
      q7_pf_in  = 64'($signed(q6_sum_ff[63:8])) + (64'(calib.p7) << 4);

      rsp_in.temperature_centi = q7_temp_ff;
      rsp_in.divisor_zero      = dz_ff[6];
      priority if (dz_ff[6] || q7_pf_ff[63]) begin
         rsp_in.pressure_q24_8 = '0;
      end else if (q7_pf_ff[62:32] != '0) begin
         rsp_in.pressure_q24_8 = '1;
      end else begin
         rsp_in.pressure_q24_8 = q7_pf_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= {valid_ff[5:0], in_valid};
         rsp_valid_ff <= valid_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_qs_ff   <= in_data.neg ? (64'd0 - in_data.quot) : in_data.quot;
         dz_ff      <= {dz_ff[5:0], in_data.dz};
         q1_temp_ff <= in_data.temp;

         q2_qs_ff   <= q1_qs_ff;
         q2_s13_ff  <= q1_qs_ff[63:13];
         q2_b_ff    <= bw[63:0];
         q2_temp_ff <= q1_temp_ff;

         q3_qs_ff   <= q2_qs_ff;
         q3_pp0_ff  <= q3_pp0_in;
         q3_pp1_ff  <= q3_pp1_in;
         q3_b_ff    <= q2_b_ff[63:19];
         q3_temp_ff <= q2_temp_ff;

         q4_qs_ff   <= q3_qs_ff;
         q4_sq_ff   <= q4_sq_in;
         q4_b_ff    <= q3_b_ff;
         q4_temp_ff <= q3_temp_ff;

         q5_qs_ff   <= q4_qs_ff;
         q5_ap_ff   <= aw[63:0];
         q5_b_ff    <= q4_b_ff;
         q5_temp_ff <= q4_temp_ff;

         q6_sum_ff  <= q6_sum_in;
         q6_temp_ff <= q5_temp_ff;

         q7_pf_ff   <= q7_pf_in;
         q7_temp_ff <= q6_temp_ff;

         rsp_ff     <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

// File: design/btpc_check.sv
module btpc_check (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input btpc_pkg::btpc_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held result beat changed");

   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow the held output");

   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divisor_zero |-> rsp_data.pressure_q24_8 == 32'd0)
      else $error("zero divisor with nonzero pressure");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind baro_temp_press_compensate btpc_check u_btpc_check (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
